>>> rtl/lfps_pkg.sv
// Shared types and constants for the LED fade pattern sequencer.
// No dependencies; imported by lfps_div and led_fade_pattern_sequencer.
`timescale 1ns / 1ps
`default_nettype none

package lfps_pkg;

    // request types
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // configuration register indexes
    localparam logic CFG_LOOP_ENABLE = 1'b0;
    localparam logic CFG_LOOP_START  = 1'b1;

    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 4;
    localparam int INDEX_W      = 4;
    localparam int START_CNT    = 1 << INDEX_W;
    localparam int LEVEL_W      = 16;
    localparam int TGT_W        = 8;
    localparam int ENTRY_W      = 3 * TGT_W;

    // divider: |diff| * tick fits in 24 bits, delay is 8 bits
    localparam int DIVIDEND_W   = 24;
    localparam int DIVISOR_W    = 8;
    localparam int DIV_ITER     = DIVIDEND_W / 2;
    localparam int DIV_CNT_W    = $clog2(DIV_ITER);

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

>>> rtl/lfps_div.sv
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on lfps_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module lfps_div
    import lfps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic      [DIVIDEND_W-1:0] quotient,
    output div_status_t                status
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVIDEND_W-1:0] dq_reg, dq_next;

    logic [DIVISOR_W:0]    r1_sh, r2_sh;
    logic [DIVISOR_W-1:0]  r1;
    logic                  ge1, ge2;

    always_comb begin
        r1_sh = {rem_reg, dq_reg[DIVIDEND_W-1]};
        ge1   = r1_sh >= {1'b0, dvs_reg};
        r1    = ge1 ? DIVISOR_W'(r1_sh - {1'b0, dvs_reg}) : r1_sh[DIVISOR_W-1:0];
        r2_sh = {r1, dq_reg[DIVIDEND_W-2]};
        ge2   = r2_sh >= {1'b0, dvs_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dq_next   = dq_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            dq_next   = dividend;
        end else if (busy_reg) begin
            rem_next = ge2 ? DIVISOR_W'(r2_sh - {1'b0, dvs_reg}) : r2_sh[DIVISOR_W-1:0];
            dq_next  = {dq_reg[DIVIDEND_W-3:0], ge1, ge2};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_ITER - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dq_reg  <= dq_next;
    end

    assign quotient    = dq_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

>>> rtl/led_fade_pattern_sequencer.sv
// Two-channel LED fade sequencer: pattern memory, tick sequencer, fade datapath.
// Depends on lfps_pkg and lfps_div (one divider per color channel).
//
//  channel  | ports                               | direction
//  ---------+-------------------------------------+----------
//  s_       | tick or pattern write request       | in
//  m_       | red/green levels, pattern_active    | out
//  cfg_     | loop_enable / loop_start writes     | in
//
// A write request gives no result; the sequencer stays idle. A fading tick
// steps through evaluate, multiply, divider start, divide, finish and output,
// its result set by the two-bit-per-cycle divider; idle ticks go from evaluate
// to output, node-completion ticks through a check state (pattern memory reads
// are registered). No clearing pass after reset; a held m_ result stalls only
// the end of the next tick, requests are taken one at a time.
`timescale 1ns / 1ps
`default_nettype none

module led_fade_pattern_sequencer
    import lfps_pkg::*;
#(
    parameter int PATTERN_DEPTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_req_type,
    input  wire logic [INDEX_W-1:0]    s_entry_index,
    input  wire logic [TGT_W-1:0]      s_entry_delay,
    input  wire logic [TGT_W-1:0]      s_entry_red,
    input  wire logic [TGT_W-1:0]      s_entry_green,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [LEVEL_W-1:0]    m_red_level,
    output logic      [LEVEL_W-1:0]    m_green_level,
    output logic                       m_pattern_active,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(PATTERN_DEPTH);
    localparam int EXT_W = 9;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DST  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_CHK  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // pattern memory {delay, red, green}
    logic [ENTRY_W-1:0] mem [PATTERN_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               mem_we;
    logic [EXT_W-1:0]   wr_idx_ext;

    logic [IDX_W-1:0]   start_lut [START_CNT];

    logic [2:0]         state_reg, state_next;
    logic               loop_en_reg, loop_en_next;
    logic [INDEX_W-1:0] loop_start_reg, loop_start_next;
    logic               running_reg, running_next;
    logic [IDX_W-1:0]   node_index_reg, node_index_next;
    logic [TGT_W-1:0]   tick_count_reg, tick_count_next;
    logic               loop_try_reg, loop_try_next;
    logic               m_valid_reg, m_valid_next;

    logic [LEVEL_W-1:0] prev_red_reg, prev_red_next;
    logic [LEVEL_W-1:0] prev_green_reg, prev_green_next;
    logic signed [LEVEL_W:0]   diff_r_reg, diff_r_next;
    logic signed [LEVEL_W:0]   diff_g_reg, diff_g_next;
    logic [TGT_W-1:0]   delay_reg, delay_next;
    logic signed [LEVEL_W+TGT_W+1:0] prod_r_reg, prod_r_next;
    logic signed [LEVEL_W+TGT_W+1:0] prod_g_reg, prod_g_next;
    logic [LEVEL_W-1:0] res_red_reg, res_red_next;
    logic [LEVEL_W-1:0] res_green_reg, res_green_next;
    logic               res_active_reg, res_active_next;
    logic [LEVEL_W-1:0] m_red_reg, m_red_next;
    logic [LEVEL_W-1:0] m_green_reg, m_green_next;
    logic               m_active_reg, m_active_next;

    logic               accept;
    logic               loop_try_now;
    logic [IDX_W-1:0]   node_wrap;
    logic [TGT_W-1:0]   rd_delay;
    logic [LEVEL_W-1:0] rd_tr, rd_tg;
    logic               run_eff;
    logic               div_start;
    logic [LEVEL_W+TGT_W+1:0] mag_r, mag_g;
    logic [DIVIDEND_W-1:0] quo_r, quo_g;
    div_status_t        st_r, st_g;
    logic               out_load;

    for (genvar g = 0; g < START_CNT; g++) begin : g_start
        assign start_lut[g] = IDX_W'(g % PATTERN_DEPTH);
    end

    assign accept       = s_valid && s_ready;
    assign s_ready      = (state_reg == S_IDLE);
    assign loop_try_now = !running_reg && loop_en_reg;
    assign node_wrap    = (node_index_reg == IDX_W'(PATTERN_DEPTH - 1))
                          ? '0 : IDX_W'(node_index_reg + 1'b1);
    assign rd_addr      = (state_reg == S_IDLE)
                          ? (loop_try_now ? start_lut[loop_start_reg] : node_index_reg)
                          : node_wrap;

    assign wr_idx_ext   = {{(EXT_W-INDEX_W){1'b0}}, s_entry_index};
    assign wr_addr      = wr_idx_ext[IDX_W-1:0];
    assign mem_we       = accept && (s_req_type == REQ_WRITE)
                          && (wr_idx_ext < EXT_W'(PATTERN_DEPTH));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= {s_entry_delay, s_entry_red, s_entry_green};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_delay = rd_data_reg[ENTRY_W-1 -: TGT_W];
    assign rd_tr    = {rd_data_reg[2*TGT_W-1 -: TGT_W], rd_data_reg[2*TGT_W-1 -: TGT_W]};
    assign rd_tg    = {rd_data_reg[TGT_W-1:0], rd_data_reg[TGT_W-1:0]};
    assign run_eff  = running_reg || (loop_try_reg && (rd_delay != '0));

    assign mag_r     = prod_r_reg[LEVEL_W+TGT_W+1] ? -prod_r_reg : prod_r_reg;
    assign mag_g     = prod_g_reg[LEVEL_W+TGT_W+1] ? -prod_g_reg : prod_g_reg;
    assign div_start = (state_reg == S_DST);
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    lfps_div u_div_red (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag_r[DIVIDEND_W-1:0]),
        .divisor  (delay_reg),
        .quotient (quo_r),
        .status   (st_r)
    );

    lfps_div u_div_green (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag_g[DIVIDEND_W-1:0]),
        .divisor  (delay_reg),
        .quotient (quo_g),
        .status   (st_g)
    );

    always_comb begin
        state_next      = state_reg;
        loop_en_next    = loop_en_reg;
        loop_start_next = loop_start_reg;
        running_next    = running_reg;
        node_index_next = node_index_reg;
        tick_count_next = tick_count_reg;
        loop_try_next   = loop_try_reg;
        prev_red_next   = prev_red_reg;
        prev_green_next = prev_green_reg;
        diff_r_next     = diff_r_reg;
        diff_g_next     = diff_g_reg;
        delay_next      = delay_reg;
        prod_r_next     = prod_r_reg;
        prod_g_next     = prod_g_reg;
        res_red_next    = res_red_reg;
        res_green_next  = res_green_reg;
        res_active_next = res_active_reg;
        m_red_next      = m_red_reg;
        m_green_next    = m_green_reg;
        m_active_next   = m_active_reg;
        m_valid_next    = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;

        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_LOOP_ENABLE: loop_en_next    = cfg_wdata[0];
                CFG_LOOP_START:  loop_start_next = cfg_wdata[INDEX_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_req_type == REQ_TICK)) begin
                    loop_try_next = loop_try_now;
                    if (loop_try_now) begin
                        node_index_next = start_lut[loop_start_reg];
                    end
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!run_eff) begin
                    tick_count_next = '0;
                    prev_red_next   = '0;
                    prev_green_next = '0;
                    res_red_next    = '0;
                    res_green_next  = '0;
                    res_active_next = 1'b0;
                    state_next      = S_OUT;
                end else if (tick_count_reg < rd_delay) begin
                    running_next = 1'b1;
                    diff_r_next  = $signed({1'b0, rd_tr}) - $signed({1'b0, prev_red_reg});
                    diff_g_next  = $signed({1'b0, rd_tg}) - $signed({1'b0, prev_green_reg});
                    delay_next   = rd_delay;
                    state_next   = S_MUL;
                end else begin
                    running_next    = 1'b1;
                    prev_red_next   = rd_tr;
                    prev_green_next = rd_tg;
                    res_red_next    = rd_tr;
                    res_green_next  = rd_tg;
                    tick_count_next = '0;
                    node_index_next = node_wrap;
                    state_next      = S_CHK;
                end
            end
            S_MUL: begin
                prod_r_next = diff_r_reg * $signed({1'b0, tick_count_reg});
                prod_g_next = diff_g_reg * $signed({1'b0, tick_count_reg});
                state_next  = S_DST;
            end
            S_DST: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (st_r.done && st_g.done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                res_red_next    = prod_r_reg[LEVEL_W+TGT_W+1]
                                  ? prev_red_reg - quo_r[LEVEL_W-1:0]
                                  : prev_red_reg + quo_r[LEVEL_W-1:0];
                res_green_next  = prod_g_reg[LEVEL_W+TGT_W+1]
                                  ? prev_green_reg - quo_g[LEVEL_W-1:0]
                                  : prev_green_reg + quo_g[LEVEL_W-1:0];
                res_active_next = 1'b1;
                tick_count_next = tick_count_reg + 1'b1;
                state_next      = S_OUT;
            end
            S_CHK: begin
                // entry after the finished node: zero delay ends the pattern
                running_next    = (rd_delay != '0);
                res_active_next = (rd_delay != '0);
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    m_red_next    = res_red_reg;
                    m_green_next  = res_green_reg;
                    m_active_next = res_active_reg;
                    m_valid_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            loop_en_reg    <= 1'b0;
            loop_start_reg <= '0;
            running_reg    <= 1'b0;
            node_index_reg <= '0;
            tick_count_reg <= '0;
            loop_try_reg   <= 1'b0;
            prev_red_reg   <= '0;
            prev_green_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            loop_en_reg    <= loop_en_next;
            loop_start_reg <= loop_start_next;
            running_reg    <= running_next;
            node_index_reg <= node_index_next;
            tick_count_reg <= tick_count_next;
            loop_try_reg   <= loop_try_next;
            prev_red_reg   <= prev_red_next;
            prev_green_reg <= prev_green_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        diff_r_reg     <= diff_r_next;
        diff_g_reg     <= diff_g_next;
        delay_reg      <= delay_next;
        prod_r_reg     <= prod_r_next;
        prod_g_reg     <= prod_g_next;
        res_red_reg    <= res_red_next;
        res_green_reg  <= res_green_next;
        res_active_reg <= res_active_next;
        m_red_reg      <= m_red_next;
        m_green_reg    <= m_green_next;
        m_active_reg   <= m_active_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_red_level      = m_red_reg;
    assign m_green_level    = m_green_reg;
    assign m_pattern_active = m_active_reg;

endmodule

`default_nettype wire
